@@ src/idst_pkg.sv @@
// Shared types, codes and pixel helper functions of the image diff checker.
`default_nettype none

package idst_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 23;
   localparam int COUNT_W     = 23;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [7:0]         CHAN_MAX  = 8'd255;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TOLERANCE = 3'd0,
      CSR_RADIUS    = 3'd1,
      CSR_WIDTH     = 3'd2,
      CSR_HEIGHT    = 3'd3,
      CSR_BUDGET    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      VERDICT_MATCH     = 2'd0,
      VERDICT_TOLERATED = 2'd1,
      VERDICT_DIFFER    = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [7:0] ref_red;
      logic [7:0] ref_green;
      logic [7:0] ref_blue;
      logic [7:0] ref_alpha;
      logic [7:0] cand_red;
      logic [7:0] cand_green;
      logic [7:0] cand_blue;
      logic [7:0] cand_alpha;
      logic       is_pad;
   } req_type;

   typedef struct packed {
      logic [7:0]         diff_red;
      logic [7:0]         diff_green;
      logic [7:0]         diff_blue;
      logic [7:0]         channel_delta;
      logic               pixel_counted;
      logic               frame_done;
      logic [COUNT_W-1:0] differing_total;
      logic [7:0]         peak_delta;
      verdict_type        verdict;
   } rsp_type;

   function automatic logic [7:0] abs_diff8(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // Largest absolute channel difference of two packed pixels (R in bits 7..0).
   function automatic logic [7:0] max_delta(input logic [31:0] a, input logic [31:0] b);
      logic [7:0] m;
      logic [7:0] d;
      m = 8'd0;
      for (int c = 0; c < 4; c++) begin
         d = abs_diff8(a[8*c +: 8], b[8*c +: 8]);
         if (d > m) begin
            m = d;
         end
      end
      return m;
   endfunction

   // True when no channel differs by more than the tolerance.
   function automatic logic pix_close(input logic [31:0] a, input logic [31:0] b,
                                      input logic [7:0] tol);
      logic ok;
      ok = 1'b1;
      for (int c = 0; c < 4; c++) begin
         if (abs_diff8(a[8*c +: 8], b[8*c +: 8]) > tol) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   // Delta times eight, saturated.
   function automatic logic [7:0] amplify(input logic [7:0] d);
      return (d[7:5] != 3'd0) ? CHAN_MAX : {d[4:0], 3'b000};
   endfunction

endpackage

`default_nettype wire

@@ src/image_diff_spatial_tolerance.sv @@
// Top level of the streaming image diff checker with tolerance and spatial slack.
//
// Usage: reference and candidate RGBA pixel pairs enter on the req_ channel in raster
// order, one beat per pixel. A result beat on the rsp_ channel carries the amplified
// color diff, the pixel's largest channel delta, whether it counts as differing and the
// running frame statistics; the beat of the frame's last pixel has frame_done set and
// the verdict. Results lag by radius*width+radius pixels, so after each frame the host
// sends that many pad beats (is_pad set); a pad inside the frame is dropped.
// Throughput is one beat per cycle while the receiver does not stall; a beat passes
// an input stage, then the result register, which presents its result. The rate is
// set by the line RAMs, which take one read and one write per row each cycle, and by the
// window compare, which checks all (2*MAX_RADIUS+1)^2 neighbors in parallel.
// When the receiver stalls, the result register holds and one more beat may sit in the
// input stage; after that req_stall rises until the result is taken.
// Reset clears the frame counters and loads the register defaults. The line RAMs need
// no clearing: pixels outside the current frame are never used by the window.
// Configuration is written on the csr_ port while no beat is in flight.
`default_nettype none

module image_diff_spatial_tolerance #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048,
   parameter int MAX_RADIUS = 2
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire idst_pkg::req_type               req_data,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      idst_pkg::rsp_type               rsp_data,
   input  wire logic                            csr_write,
   input  wire logic [idst_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [idst_pkg::CSR_DATA_W-1:0]  csr_data
);

   import idst_pkg::*;

   localparam int TAPS    = 2 * MAX_RADIUS + 1;
   localparam int LINES   = 2 * MAX_RADIUS;
   localparam int CW      = $clog2(MAX_WIDTH);
   localparam int HW      = $clog2(MAX_HEIGHT);
   localparam int WB      = $clog2(MAX_WIDTH + 1);
   localparam int HB      = $clog2(MAX_HEIGHT + 1);
   localparam int RB      = $clog2(MAX_RADIUS + 1);
   localparam int TOT_MAX = MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH + MAX_RADIUS;
   localparam int NW      = $clog2(TOT_MAX + 1);
   localparam int CMPW    = $clog2(MAX_WIDTH + MAX_HEIGHT + 4 * MAX_RADIUS + 4) + 1;
   localparam int PW      = 64;

   // Reset values of the derived frame geometry.
   localparam int W_RST   = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
   localparam int H_RST   = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;
   localparam int TOT_RST = W_RST * H_RST;

   // Control that travels with a beat through the window stage.
   typedef struct packed {
      logic            emit;
      logic            done;
      logic            restart;
      logic [TAPS-1:0] row_ok;
      logic [TAPS-1:0] col_ok;
   } stage_ctl_type;

   // ------------------------------------------------------------------
   // Configuration registers and derived geometry
   // ------------------------------------------------------------------
   logic [7:0]         tol_ff, tol_in;
   logic [1:0]         rad_ff, rad_in;
   logic [11:0]        wcfg_ff, wcfg_in;
   logic [11:0]        hcfg_ff, hcfg_in;
   logic [COUNT_W-1:0] budget_ff, budget_in;

   logic [WB-1:0]      w_ff, w_in;
   logic [HB-1:0]      h_ff, h_in;
   logic [RB-1:0]      r_ff, r_in;
   logic [NW-1:0]      total_ff, total_in;
   logic [NW-1:0]      lag_ff, lag_in;
   logic [NW-1:0]      last_ff, last_in;
   logic [NW-1:0]      flush_ff, flush_in;

   logic [31:0]        w_clamp, h_clamp, r_clamp, tot32, lag32;

   always_comb begin
      tol_in    = tol_ff;
      rad_in    = rad_ff;
      wcfg_in   = wcfg_ff;
      hcfg_in   = hcfg_ff;
      budget_in = budget_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_TOLERANCE: tol_in    = csr_data[7:0];
            CSR_RADIUS:    rad_in    = csr_data[1:0];
            CSR_WIDTH:     wcfg_in   = csr_data[11:0];
            CSR_HEIGHT:    hcfg_in   = csr_data[11:0];
            CSR_BUDGET:    budget_in = csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end

      // A zero dimension is taken as one; larger values saturate at the maximum.
      w_clamp = 32'(wcfg_in);
      if (w_clamp == 32'd0) begin
         w_clamp = 32'd1;
      end else if (w_clamp > 32'(MAX_WIDTH)) begin
         w_clamp = 32'(MAX_WIDTH);
      end
      h_clamp = 32'(hcfg_in);
      if (h_clamp == 32'd0) begin
         h_clamp = 32'd1;
      end else if (h_clamp > 32'(MAX_HEIGHT)) begin
         h_clamp = 32'(MAX_HEIGHT);
      end
      r_clamp = 32'(rad_in);
      if (r_clamp > 32'(MAX_RADIUS)) begin
         r_clamp = 32'(MAX_RADIUS);
      end

      tot32    = w_clamp * h_clamp;
      lag32    = r_clamp * w_clamp + r_clamp;
      w_in     = WB'(w_clamp);
      h_in     = HB'(h_clamp);
      r_in     = RB'(r_clamp);
      total_in = NW'(tot32);
      lag_in   = NW'(lag32);
      flush_in = NW'(tot32 + lag32);
      last_in  = NW'(tot32 + lag32 - 32'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff    <= 8'd2;
         rad_ff    <= 2'd0;
         wcfg_ff   <= 12'd640;
         hcfg_ff   <= 12'd480;
         budget_ff <= '0;
         w_ff      <= WB'(W_RST);
         h_ff      <= HB'(H_RST);
         r_ff      <= '0;
         total_ff  <= NW'(TOT_RST);
         lag_ff    <= '0;
         flush_ff  <= NW'(TOT_RST);
         last_ff   <= NW'(TOT_RST - 1);
      end else begin
         tol_ff    <= tol_in;
         rad_ff    <= rad_in;
         wcfg_ff   <= wcfg_in;
         hcfg_ff   <= hcfg_in;
         budget_ff <= budget_in;
         w_ff      <= w_in;
         h_ff      <= h_in;
         r_ff      <= r_in;
         total_ff  <= total_in;
         lag_ff    <= lag_in;
         flush_ff  <= flush_in;
         last_ff   <= last_in;
      end
   end

   // ------------------------------------------------------------------
   // Input side: beat sequencing and output position
   // ------------------------------------------------------------------
   logic          s1_valid_ff, s1_valid_in;
   stage_ctl_type s1_ctl_ff, s1_ctl_in;
   logic [PW-1:0] s1_pix_ff;
   logic          s1_move;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [NW-1:0] n_ff, n_in;
   logic [CW-1:0] in_col_ff, in_col_in;
   logic [CW-1:0] px_ff, px_in;
   logic [HW-1:0] py_ff, py_in;

   logic          take;
   logic          ignored;
   logic          adv;
   logic          has_lag;
   logic          restart;
   logic          emit;
   logic          done;
   logic [CMPW-1:0] yr, xr, kk;

   assign s1_move   = !s1_ctl_ff.emit || !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_move;
   assign take      = req_valid && !req_stall;

   // A pad while pixels of the frame are still due is dropped without a trace.
   assign ignored = (n_ff < total_ff) && req_data.is_pad;
   assign adv     = take && !ignored;
   assign has_lag = (n_ff >= lag_ff);
   assign restart = has_lag && (n_ff >= flush_ff);
   assign emit    = has_lag && !restart;
   assign done    = emit && (n_ff == last_ff);

   always_comb begin
      n_in      = n_ff;
      in_col_in = in_col_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      if (adv) begin
         if (restart || done) begin
            n_in      = '0;
            in_col_in = '0;
            px_in     = '0;
            py_in     = '0;
         end else begin
            n_in = n_ff + NW'(1);
            if (WB'(in_col_ff) == w_ff - WB'(1)) begin
               in_col_in = '0;
            end else begin
               in_col_in = in_col_ff + CW'(1);
            end
            if (emit) begin
               if (WB'(px_ff) == w_ff - WB'(1)) begin
                  px_in = '0;
                  py_in = py_ff + HW'(1);
               end else begin
                  px_in = px_ff + CW'(1);
               end
            end
         end
      end
   end

   // Window masks: row tap k sits dy = r - k rows from the output pixel, column tap j
   // sits dx = r - j columns from it. Taps beyond the radius or the frame are masked.
   always_comb begin
      s1_ctl_in.emit    = emit;
      s1_ctl_in.done    = done;
      s1_ctl_in.restart = restart;
      yr = CMPW'(py_ff) + CMPW'(r_ff);
      xr = CMPW'(px_ff) + CMPW'(r_ff);
      kk = '0;
      for (int k = 0; k < TAPS; k++) begin
         kk = CMPW'(k);
         s1_ctl_in.row_ok[k] = (kk <= (CMPW'(r_ff) << 1)) && (kk <= yr) &&
                               (yr <= CMPW'(h_ff) - CMPW'(1) + kk);
         s1_ctl_in.col_ok[k] = (kk <= (CMPW'(r_ff) << 1)) && (kk <= xr) &&
                               (xr <= CMPW'(w_ff) - CMPW'(1) + kk);
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (adv) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff        <= '0;
         in_col_ff   <= '0;
         px_ff       <= '0;
         py_ff       <= '0;
         s1_valid_ff <= 1'b0;
         s1_ctl_ff   <= '0;
      end else begin
         n_ff        <= n_in;
         in_col_ff   <= in_col_in;
         px_ff       <= px_in;
         py_ff       <= py_in;
         s1_valid_ff <= s1_valid_in;
         if (adv) begin
            s1_ctl_ff <= s1_ctl_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pix_ff <= {req_data.cand_alpha, req_data.cand_blue, req_data.cand_green,
                       req_data.cand_red, req_data.ref_alpha, req_data.ref_blue,
                       req_data.ref_green, req_data.ref_red};
      end
   end

   // ------------------------------------------------------------------
   // Line buffers: stream k carries the pixel k rows above the newest one.
   // Line RAM i delays stream i by one row into stream i+1.
   // ------------------------------------------------------------------
   logic [PW-1:0] strm      [TAPS];
   logic [PW-1:0] ram_rd    [LINES];
   logic [PW-1:0] byp_data_ff [LINES];
   logic          byp_ff;
   logic          wr_pend_ff;
   logic [CW-1:0] wr_addr_ff;
   logic [PW-1:0] hist_ff   [TAPS][LINES];

   for (genvar i = 0; i < LINES; i++) begin : g_line
      idst_ram #(
         .WIDTH (PW),
         .DEPTH (MAX_WIDTH)
      ) u_line_ram (
         .clock   (clock),
         .wr_en   (wr_pend_ff),
         .wr_addr (wr_addr_ff),
         .wr_data (strm[i]),
         .rd_en   (adv),
         .rd_addr (in_col_ff),
         .rd_data (ram_rd[i])
      );
   end

   always_comb begin
      strm[0] = s1_pix_ff;
      for (int i = 0; i < LINES; i++) begin
         strm[i+1] = byp_ff ? byp_data_ff[i] : ram_rd[i];
      end
   end

   // With a one-pixel row the read and the write of consecutive beats hit the same
   // address; the written value is forwarded past the RAM.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pend_ff <= 1'b0;
         byp_ff     <= 1'b0;
      end else begin
         wr_pend_ff <= adv;
         if (adv) begin
            byp_ff <= wr_pend_ff && (wr_addr_ff == in_col_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         wr_addr_ff <= in_col_ff;
         for (int i = 0; i < LINES; i++) begin
            byp_data_ff[i] <= strm[i];
         end
         for (int k = 0; k < TAPS; k++) begin
            hist_ff[k][0] <= strm[k];
            for (int j = 1; j < LINES; j++) begin
               hist_ff[k][j] <= hist_ff[k][j-1];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Window compare
   // ------------------------------------------------------------------
   logic [PW-1:0] tap [TAPS][TAPS];
   logic [PW-1:0] center;
   logic [7:0]    m;
   logic          ref_found;
   logic          cand_found;
   logic          counted;

   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         tap[k][0] = strm[k];
         for (int j = 1; j < TAPS; j++) begin
            tap[k][j] = hist_ff[k][j-1];
         end
      end
      center = tap[0][0];
      for (int i = 1; i <= MAX_RADIUS; i++) begin
         if (r_ff == RB'(i)) begin
            center = tap[i][i];
         end
      end
      m = max_delta(center[31:0], center[63:32]);
      ref_found  = 1'b0;
      cand_found = 1'b0;
      for (int k = 0; k < TAPS; k++) begin
         for (int j = 0; j < TAPS; j++) begin
            if (s1_ctl_ff.row_ok[k] && s1_ctl_ff.col_ok[j]) begin
               if (pix_close(center[31:0], tap[k][j][63:32], tol_ff)) begin
                  ref_found = 1'b1;
               end
               if (pix_close(center[63:32], tap[k][j][31:0], tol_ff)) begin
                  cand_found = 1'b1;
               end
            end
         end
      end
      counted = (m > tol_ff) && !(ref_found && cand_found);
   end

   // ------------------------------------------------------------------
   // Frame statistics and result register
   // ------------------------------------------------------------------
   logic [COUNT_W-1:0] cnt_ff, cnt_in, cnt_new;
   logic [7:0]         peak_ff, peak_in, peak_new;
   logic               s1_fire;
   logic               load;
   rsp_type            rsp_ff, rsp_in;

   assign s1_fire = s1_valid_ff && s1_move;
   assign load    = s1_fire && s1_ctl_ff.emit;

   always_comb begin
      cnt_new  = (counted && (cnt_ff != COUNT_MAX)) ? cnt_ff + COUNT_W'(1) : cnt_ff;
      peak_new = (m > peak_ff) ? m : peak_ff;
      cnt_in   = cnt_ff;
      peak_in  = peak_ff;
      if (s1_fire) begin
         if (s1_ctl_ff.restart || s1_ctl_ff.done) begin
            cnt_in  = '0;
            peak_in = '0;
         end else if (s1_ctl_ff.emit) begin
            cnt_in  = cnt_new;
            peak_in = peak_new;
         end
      end

      rsp_in.diff_red        = amplify(abs_diff8(center[7:0],   center[39:32]));
      rsp_in.diff_green      = amplify(abs_diff8(center[15:8],  center[47:40]));
      rsp_in.diff_blue       = amplify(abs_diff8(center[23:16], center[55:48]));
      rsp_in.channel_delta   = m;
      rsp_in.pixel_counted   = counted;
      rsp_in.frame_done      = s1_ctl_ff.done;
      rsp_in.differing_total = cnt_new;
      rsp_in.peak_delta      = peak_new;
      rsp_in.verdict         = VERDICT_MATCH;
      if (s1_ctl_ff.done && (cnt_new != '0)) begin
         if ((budget_ff != '0) && (cnt_new <= budget_ff)) begin
            rsp_in.verdict = VERDICT_TOLERATED;
         end else begin
            rsp_in.verdict = VERDICT_DIFFER;
         end
      end

      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------

   // A pad dropped inside the frame leaves the beat counter untouched.
   assert property (@(posedge clock) disable iff (reset)
      (take && ignored) |=> (n_ff == $past(n_ff)))
      else $error("dropped pad advanced the beat counter");

   // The last pixel of a frame clears the statistics for the next frame.
   assert property (@(posedge clock) disable iff (reset)
      (load && s1_ctl_ff.done) |=> (cnt_ff == '0 && peak_ff == '0))
      else $error("frame statistics not cleared after the last pixel");

   // Only the last result of a frame carries a verdict.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.frame_done) |-> (rsp_data.verdict == VERDICT_MATCH))
      else $error("verdict outside the frame's last result");

   // A counted pixel always exceeds the channel tolerance.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.pixel_counted) |-> (rsp_data.channel_delta > tol_ff))
      else $error("pixel counted within tolerance");

endmodule

`default_nettype wire

@@ src/idst_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module idst_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the image diff checker with tolerance and spatial slack.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
   import idst_pkg::*;

   // Sizes of the block as built with its default parameters.
   localparam int FRAME_MAX_W = 2048;
   localparam int FRAME_MAX_H = 2048;
   localparam int RADIUS_MAX  = 2;
   localparam int WINDOW_DEPTH = 2 * RADIUS_MAX * FRAME_MAX_W + 2 * RADIUS_MAX + 1;
   // Cycles without any accepted beat before the run is declared hung.
   localparam int HANG_LIMIT = 4000;
   // Cycles a beat may still be inside the block after its last result left.
   localparam int DRAIN_CYCLES = 8;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   image_diff_spatial_tolerance dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // Shadow copy of the configuration registers, as written.
   logic [7:0]  tol_reg;
   logic [1:0]  radius_reg;
   logic [11:0] width_reg;
   logic [11:0] height_reg;
   logic [22:0] budget_reg;

   // Shadow copy of the frame state: pixel windows and running statistics.
   logic [31:0] ref_window [WINDOW_DEPTH];
   logic [31:0] cand_window [WINDOW_DEPTH];
   int unsigned frame_pos;
   logic [22:0] diff_count;
   logic [7:0]  frame_peak;

   rsp_type pending_results[$];
   int      errors;
   int      pixels_sent;
   int      hang_count;
   int      stall_left;
   bit      quiet;
   bit      req_fire;
   bit      rsp_fire;

   always #6 clock = ~clock;

   // Largest absolute difference over the four channels of two packed pixels.
   function automatic int pixel_spread(logic [31:0] a, logic [31:0] b);
      int m;
      int d;
      m = 0;
      for (int c = 0; c < 4; c++) begin
         d = int'(a[8*c +: 8]) - int'(b[8*c +: 8]);
         if (d < 0) begin
            d = -d;
         end
         if (d > m) begin
            m = d;
         end
      end
      return m;
   endfunction

   function automatic logic [7:0] boosted(logic [7:0] a, logic [7:0] b);
      int d;
      d = (a > b) ? a - b : b - a;
      return (d * 8 > 255) ? 8'd255 : 8'(d * 8);
   endfunction

   function automatic int eff_width();
      return (width_reg == 0) ? 1 : ((width_reg > FRAME_MAX_W) ? FRAME_MAX_W : width_reg);
   endfunction

   function automatic int eff_height();
      return (height_reg == 0) ? 1 : ((height_reg > FRAME_MAX_H) ? FRAME_MAX_H : height_reg);
   endfunction

   function automatic int eff_radius();
      return (radius_reg > RADIUS_MAX) ? RADIUS_MAX : radius_reg;
   endfunction

   function automatic void clear_frame();
      frame_pos = 0;
      diff_count = '0;
      frame_peak = '0;
   endfunction

   // Works out what one accepted input beat produces and queues the expected result.
   function automatic void predict_beat(req_type beat);
      int w, h, r, total, lag, n, p, x, y, m, tol;
      int ylo, yhi, xlo, xhi, q;
      logic [31:0] rp, cp;
      bit ref_hit, cand_hit, counted;
      rsp_type want;
      w = eff_width();
      h = eff_height();
      r = eff_radius();
      tol = tol_reg;
      total = w * h;
      lag = r * w + r;
      n = frame_pos;
      if (n < total) begin
         // Inside the pixel phase a pad is simply dropped.
         if (beat.is_pad) begin
            return;
         end
         ref_window[n % WINDOW_DEPTH] = {beat.ref_alpha, beat.ref_blue,
                                         beat.ref_green, beat.ref_red};
         cand_window[n % WINDOW_DEPTH] = {beat.cand_alpha, beat.cand_blue,
                                          beat.cand_green, beat.cand_red};
      end
      frame_pos = n + 1;
      if (n < lag) begin
         return;
      end
      p = n - lag;
      // The output position ran past the frame, as after a size change: start over.
      if (p >= total) begin
         clear_frame();
         return;
      end
      x = p % w;
      y = p / w;
      rp = ref_window[p % WINDOW_DEPTH];
      cp = cand_window[p % WINDOW_DEPTH];
      m = pixel_spread(rp, cp);
      if (m > frame_peak) begin
         frame_peak = 8'(m);
      end
      counted = 1'b0;
      if (m > tol) begin
         ref_hit = 1'b0;
         cand_hit = 1'b0;
         if (r > 0) begin
            ylo = (y >= r) ? y - r : 0;
            yhi = (y + r < h) ? y + r : h - 1;
            xlo = (x >= r) ? x - r : 0;
            xhi = (x + r < w) ? x + r : w - 1;
            for (int ny = ylo; ny <= yhi; ny++) begin
               for (int nx = xlo; nx <= xhi; nx++) begin
                  q = (ny * w + nx) % WINDOW_DEPTH;
                  if (pixel_spread(rp, cand_window[q]) <= tol) begin
                     ref_hit = 1'b1;
                  end
                  if (pixel_spread(cp, ref_window[q]) <= tol) begin
                     cand_hit = 1'b1;
                  end
               end
            end
         end
         // Slack only forgives a pixel when the match holds in both directions.
         if (!(ref_hit && cand_hit)) begin
            counted = 1'b1;
            if (diff_count != COUNT_MAX) begin
               diff_count = diff_count + 1'b1;
            end
         end
      end
      want.diff_red = boosted(rp[7:0], cp[7:0]);
      want.diff_green = boosted(rp[15:8], cp[15:8]);
      want.diff_blue = boosted(rp[23:16], cp[23:16]);
      want.channel_delta = 8'(m);
      want.pixel_counted = counted;
      want.frame_done = (p == total - 1);
      want.differing_total = diff_count;
      want.peak_delta = frame_peak;
      want.verdict = VERDICT_MATCH;
      if (want.frame_done) begin
         if (diff_count == 0) begin
            want.verdict = VERDICT_MATCH;
         end else if (budget_reg != 0 && diff_count <= budget_reg) begin
            want.verdict = VERDICT_TOLERATED;
         end else begin
            want.verdict = VERDICT_DIFFER;
         end
         clear_frame();
      end
      pending_results.push_back(want);
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // Result side: compare every accepted beat with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      rsp_fire = rsp_valid === 1'b1 && rsp_stall === 1'b0 && !reset;
      req_fire = req_valid === 1'b1 && req_stall === 1'b0 && !reset;
      if (rsp_fire) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, expected none, actual %h", $time,
                     rsp_data);
         end else begin
            want = pending_results.pop_front();
            check_field("diff_red", want.diff_red, rsp_data.diff_red);
            check_field("diff_green", want.diff_green, rsp_data.diff_green);
            check_field("diff_blue", want.diff_blue, rsp_data.diff_blue);
            check_field("channel_delta", want.channel_delta, rsp_data.channel_delta);
            check_field("pixel_counted", want.pixel_counted, rsp_data.pixel_counted);
            check_field("frame_done", want.frame_done, rsp_data.frame_done);
            check_field("differing_total", want.differing_total, rsp_data.differing_total);
            check_field("peak_delta", want.peak_delta, rsp_data.peak_delta);
            check_field("verdict", want.verdict, rsp_data.verdict);
         end
         stall_left = quiet ? 0 : $urandom_range(0, 8);
      end
      // The watchdog only counts cycles in which neither channel moved a beat.
      if (rsp_fire || req_fire || reset) begin
         hang_count = 0;
      end else begin
         hang_count++;
         if (hang_count >= HANG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Receiver stall: held for the drawn number of cycles after each taken result.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // Sends one beat after a random gap and returns at the falling edge after it was
   // taken, with valid still high so that back-to-back beats need no toggle.
   task automatic send_beat(input req_type beat);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = beat;
      @(posedge clock);
      while (req_stall !== 1'b0) begin
         @(posedge clock);
      end
      predict_beat(beat);
      @(negedge clock);
   endtask

   // Registers change only once the block is empty and its pipeline has drained.
   task automatic write_reg(input csr_index_type idx, input logic [22:0] value);
      req_valid = 1'b0;
      while (pending_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         CSR_TOLERANCE: tol_reg = value[7:0];
         CSR_RADIUS:    radius_reg = value[1:0];
         CSR_WIDTH:     width_reg = value[11:0];
         CSR_HEIGHT:    height_reg = value[11:0];
         CSR_BUDGET:    budget_reg = value;
         default: ;
      endcase
   endtask

   task automatic setup(input int tol, input int r, input int w, input int h,
                        input logic [22:0] budget);
      write_reg(CSR_TOLERANCE, 23'(tol));
      write_reg(CSR_RADIUS, 23'(r));
      write_reg(CSR_WIDTH, 23'(w));
      write_reg(CSR_HEIGHT, 23'(h));
      write_reg(CSR_BUDGET, budget);
   endtask

   function automatic req_type make_pixel(logic [31:0] rp, logic [31:0] cp);
      req_type beat;
      beat.ref_red = rp[7:0];
      beat.ref_green = rp[15:8];
      beat.ref_blue = rp[23:16];
      beat.ref_alpha = rp[31:24];
      beat.cand_red = cp[7:0];
      beat.cand_green = cp[15:8];
      beat.cand_blue = cp[23:16];
      beat.cand_alpha = cp[31:24];
      beat.is_pad = 1'b0;
      return beat;
   endfunction

   // Streams a frame, a few stray pads mixed in, and then the flush beats. The flush
   // beats carry random pixel fields and a random pad flag, since the block must
   // ignore both there. A negative flush count means the full lag.
   task automatic play_frame(input logic [31:0] rimg[$], input logic [31:0] cimg[$],
                             input int flush);
      req_type beat;
      int lag;
      lag = eff_radius() * eff_width() + eff_radius();
      if (flush < 0) begin
         flush = lag;
      end
      for (int k = 0; k < rimg.size(); k++) begin
         if ($urandom_range(0, 11) == 0) begin
            beat = req_type'({$urandom, $urandom, 1'b1});
            send_beat(beat);
         end
         send_beat(make_pixel(rimg[k], cimg[k]));
         pixels_sent++;
      end
      for (int k = 0; k < flush; k++) begin
         beat = req_type'({$urandom, $urandom, 1'($urandom)});
         send_beat(beat);
      end
   endtask

   // Builds a frame from a small palette so that neighbors often agree; candidates
   // are near copies, copies of a neighbor, exact copies or plain noise.
   task automatic random_frame(input int total, input int w, input int noise_max);
      logic [31:0] rimg[$];
      logic [31:0] cimg[$];
      logic [31:0] palette[4];
      logic [31:0] px;
      int nb;
      palette[0] = 32'h0;
      palette[1] = 32'hFFFF_FFFF;
      palette[2] = $urandom;
      palette[3] = $urandom;
      for (int k = 0; k < total; k++) begin
         rimg.push_back(($urandom_range(0, 5) == 0) ? $urandom : palette[$urandom_range(0, 3)]);
      end
      for (int k = 0; k < total; k++) begin
         case ($urandom_range(0, 4))
            0, 1: begin
               px = rimg[k];
               for (int c = 0; c < 4; c++) begin
                  px[8*c +: 8] = px[8*c +: 8] ^ 8'($urandom_range(0, noise_max));
               end
            end
            2: begin
               case ($urandom_range(0, 3))
                  0: nb = k - 1;
                  1: nb = k + 1;
                  2: nb = k - w;
                  default: nb = k + w;
               endcase
               nb = (nb < 0) ? 0 : ((nb >= total) ? total - 1 : nb);
               px = rimg[nb];
            end
            3: px = $urandom;
            default: px = rimg[k];
         endcase
         cimg.push_back(px);
      end
      play_frame(rimg, cimg, -1);
   endtask

   // Channel extremes, the saturation edge of the boosted diff, alpha-only change and
   // a delta just past the tolerance, first with no tolerance and then the largest.
   task automatic test_pixel_extremes();
      logic [31:0] rimg[$];
      logic [31:0] cimg[$];
      quiet = 1'b1;
      rimg = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
               32'h1020_3040, 32'hFFFF_FFFF};
      cimg = '{32'hFFFF_FFFF, 32'hFF00_0000, 32'h0020_1F1F, 32'h0000_0020,
               32'h1020_3041, 32'hFFFF_FFFF};
      setup(0, 0, 3, 2, 0);
      play_frame(rimg, cimg, -1);
      write_reg(CSR_TOLERANCE, 23'd255);
      play_frame(rimg, cimg, -1);
      quiet = 1'b0;
   endtask

   // Budget settings: tolerated within budget, differ past it, the largest budget.
   task automatic test_budget();
      logic [31:0] rimg[$];
      logic [31:0] cimg[$];
      rimg = '{32'h0, 32'h0, 32'h0};
      cimg = '{32'h0000_0009, 32'h0, 32'h0900_0000};
      setup(2, 0, 3, 1, 23'd2);
      play_frame(rimg, cimg, -1);
      write_reg(CSR_BUDGET, 23'd1);
      play_frame(rimg, cimg, -1);
      write_reg(CSR_BUDGET, 23'h7F_FFFF);
      play_frame(rimg, cimg, -1);
      write_reg(CSR_BUDGET, 23'd4194304);
      play_frame(rimg, cimg, -1);
   endtask

   // Spatial slack on random frames whose candidates often copy a neighbor, with the radius above its maximum as well.
   task automatic test_slack();
      setup(3, 1, 5, 4, 0);
      random_frame(20, 5, 3);
      write_reg(CSR_RADIUS, 23'd2);
      random_frame(20, 5, 3);
      write_reg(CSR_RADIUS, 23'd3);
      random_frame(20, 5, 3);
   endtask

   // Zero sizes read as one. Oversize sizes are run on part of a frame only: the
   // results must keep coming with frame_done low. Shrinking the frame to one pixel
   // then puts the output position past its end, and the next beat restarts it.
   task automatic test_frame_sizes();
      logic [31:0] rimg[$];
      logic [31:0] cimg[$];
      req_type beat;
      setup(1, 0, 0, 0, 0);
      random_frame(1, 1, 3);
      for (int k = 0; k < 24; k++) begin
         rimg.push_back($urandom);
         cimg.push_back(($urandom_range(0, 1) == 0) ? rimg[k] : $urandom);
      end
      write_reg(CSR_WIDTH, 23'd4095);
      play_frame(rimg, cimg, 0);
      setup(1, 0, 1, 4095, 23'd5);
      play_frame(rimg, cimg, 0);
      write_reg(CSR_HEIGHT, 23'd1);
      beat = req_type'({$urandom, $urandom, 1'b1});
      send_beat(beat);
      setup(0, 3, 4, 2, 0);
      random_frame(8, 4, 3);
   endtask

   // A size change while the frame is flushing: the output position already lies past
   // the new frame, so the next beat is absorbed without a result and a frame restarts.
   task automatic test_resize_in_flush();
      req_type beat;
      setup(2, 2, 4, 4, 0);
      random_frame(16, 4, 3);
      setup(2, 2, 4, 4, 0);
      // Only part of the flush goes out before the resize.
      begin
         logic [31:0] rimg[$];
         logic [31:0] cimg[$];
         for (int k = 0; k < 16; k++) begin
            rimg.push_back($urandom);
            cimg.push_back($urandom);
         end
         play_frame(rimg, cimg, 4);
      end
      write_reg(CSR_WIDTH, 23'd2);
      beat = req_type'({$urandom, $urandom, 1'b1});
      send_beat(beat);
      random_frame(8, 2, 3);
   endtask

   task automatic test_random_frames();
      int w, h;
      int start;
      start = pixels_sent;
      while (pixels_sent - start < 180) begin
         w = $urandom_range(1, 10);
         h = $urandom_range(1, 6);
         quiet = ($urandom_range(0, 3) == 0);
         setup($urandom_range(0, 2) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 6),
               $urandom_range(0, 3), w, h,
               ($urandom_range(0, 3) == 0) ? 23'h7F_FFFF : 23'($urandom_range(0, 6)));
         random_frame(w * h, w, $urandom_range(0, 15));
      end
      quiet = 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      errors = 0;
      pixels_sent = 0;
      hang_count = 0;
      stall_left = 0;
      quiet = 1'b0;
      tol_reg = 8'd2;
      radius_reg = 2'd0;
      width_reg = 12'd640;
      height_reg = 12'd480;
      budget_reg = '0;
      clear_frame();
      repeat (11) @(negedge clock);
      reset = 1'b0;

      test_pixel_extremes();
      test_budget();
      test_slack();
      test_frame_sizes();
      test_resize_in_flush();
      test_random_frames();

      // Drain: the watchdog covers a result that never arrives.
      req_valid = 1'b0;
      while (pending_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
